// File: rtl/tsem_pkg.sv
// ----------------------------------------------------------------------------
// tsem_pkg: shared types and constants for the touch sample event mapper
// Request payloads, classified work items, queue status and register codes.
// ----------------------------------------------------------------------------
package tsem_pkg;

  // default geometry and gain format
  localparam int DEF_UI_WIDTH       = 1280;
  localparam int DEF_UI_HEIGHT      = 720;
  localparam int DEF_GAIN_FRAC_BITS = 12;

  // field widths
  localparam int RAW_W    = 11;
  localparam int UI_X_W   = 11;
  localparam int UI_Y_W   = 10;
  localparam int CNT_W    = 32;
  localparam int XOFF_W   = 12;
  localparam int YOFF_W   = 11;
  localparam int GAIN_W   = 16;

  // internal arithmetic widths
  localparam int XSUM_W   = 14;
  localparam int PROD_W   = 28;
  localparam int YSUM_W   = 29;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_X_OFFSET = 2'd0;
  localparam logic [1:0] REG_Y_OFFSET = 2'd1;
  localparam logic [1:0] REG_Y_GAIN   = 2'd2;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_DOWN    = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // sample classes decided by the front
  typedef enum logic [1:0] {
    CLS_FAULT = 2'd0,
    CLS_TOUCH = 2'd1,
    CLS_IDLE  = 2'd2
  } sample_cls_t;

  typedef struct packed {
    logic              read_ok;
    logic              is_pressed;
    logic [3:0]        point_count;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [UI_X_W-1:0] ui_x;
    logic [UI_Y_W-1:0] ui_y;
    logic [CNT_W-1:0]  sample_total;
    logic [CNT_W-1:0]  press_total;
    logic [CNT_W-1:0]  fault_total;
  } out_item_t;

  typedef struct packed {
    sample_cls_t              cls;
    logic signed [XSUM_W-1:0] x_sum;
    logic signed [PROD_W-1:0] y_prod;
  } work_item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// File: rtl/tsem_front.sv
// ----------------------------------------------------------------------------
// tsem_front: request intake and classification
// Classifies each sample, forms the rotated x sum and the y gain product,
// and holds the result in one register until the queue takes it.
// ----------------------------------------------------------------------------
module tsem_front #(
  parameter int UI_WIDTH = tsem_pkg::DEF_UI_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  tsem_pkg::in_item_t                    in_data,
  input  logic signed [tsem_pkg::XOFF_W-1:0]    x_offset,
  input  logic signed [tsem_pkg::GAIN_W-1:0]    y_gain,
  input  tsem_pkg::q_stat_t                     q_stat,
  output logic                                  push,
  output tsem_pkg::work_item_t                  push_data
);
  import tsem_pkg::*;

  logic       f_vld_r;
  logic       f_vld_nxt;
  work_item_t f_item_r;
  work_item_t f_item_nxt;
  logic       accept;

  // handshake with the queue
  assign push     = f_vld_r && !q_stat.full;
  assign in_stall = f_vld_r && q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      f_vld_nxt = 1'b1;
    end else if (push) begin
      f_vld_nxt = 1'b0;
    end else begin
      f_vld_nxt = f_vld_r;
    end
  end

  // classify and compute the coordinate terms
  always_comb begin
    if (!in_data.read_ok) begin
      f_item_nxt.cls = CLS_FAULT;
    end else if (in_data.is_pressed && (in_data.point_count != 4'd0)) begin
      f_item_nxt.cls = CLS_TOUCH;
    end else begin
      f_item_nxt.cls = CLS_IDLE;
    end
    f_item_nxt.x_sum = XSUM_W'(UI_WIDTH - 1)
                     - $signed({{(XSUM_W-RAW_W){1'b0}}, in_data.raw_y})
                     + XSUM_W'(x_offset);
    f_item_nxt.y_prod = $signed({{(PROD_W-RAW_W){1'b0}}, in_data.raw_x})
                      * PROD_W'(y_gain);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  // payload register, loaded on each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign push_data = f_item_r;

endmodule

// File: rtl/tsem_queue.sv
// ----------------------------------------------------------------------------
// tsem_queue: short work queue between front and back
// Circular buffer with read and write pointers and an entry count.
// ----------------------------------------------------------------------------
module tsem_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tsem_pkg::work_item_t  push_data,
  input  logic                  pop,
  output tsem_pkg::work_item_t  pop_data,
  output tsem_pkg::q_stat_t     q_stat
);
  import tsem_pkg::*;

  work_item_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  // pointer advance with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data         = entry_r[rd_ptr_r];
  assign q_stat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.not_empty = (count_r != '0);

endmodule

// File: rtl/tsem_back.sv
// ----------------------------------------------------------------------------
// tsem_back: touch state update and result register
// Finishes the y scaling, clamps both coordinates, updates the held point
// and the counters, and presents one result per queued sample.
// ----------------------------------------------------------------------------
module tsem_back #(
  parameter int UI_WIDTH       = tsem_pkg::DEF_UI_WIDTH,
  parameter int UI_HEIGHT      = tsem_pkg::DEF_UI_HEIGHT,
  parameter int GAIN_FRAC_BITS = tsem_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tsem_pkg::q_stat_t                   q_stat,
  input  tsem_pkg::work_item_t                q_data,
  output logic                                pop,
  input  logic signed [tsem_pkg::YOFF_W-1:0]  y_offset,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tsem_pkg::out_item_t                 out_data
);
  import tsem_pkg::*;

  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << GAIN_FRAC_BITS) - 1);
  localparam logic [UI_X_W-1:0]        X_MAX      = UI_X_W'(UI_WIDTH - 1);
  localparam logic [UI_Y_W-1:0]        Y_MAX      = UI_Y_W'(UI_HEIGHT - 1);

  logic                     held_r;
  logic                     held_nxt;
  logic [UI_X_W-1:0]        held_x_r;
  logic [UI_X_W-1:0]        held_x_nxt;
  logic [UI_Y_W-1:0]        held_y_r;
  logic [UI_Y_W-1:0]        held_y_nxt;
  logic [CNT_W-1:0]         sample_cnt_r;
  logic [CNT_W-1:0]         sample_cnt_nxt;
  logic [CNT_W-1:0]         press_cnt_r;
  logic [CNT_W-1:0]         press_cnt_nxt;
  logic [CNT_W-1:0]         fault_cnt_r;
  logic [CNT_W-1:0]         fault_cnt_nxt;
  logic                     out_vld_r;
  logic                     out_vld_nxt;
  out_item_t                out_data_r;
  out_item_t                out_data_nxt;
  logic signed [PROD_W-1:0] y_biased;
  logic signed [PROD_W-1:0] y_scaled;
  logic signed [YSUM_W-1:0] y_sum;
  logic [UI_X_W-1:0]        x_clamped;
  logic [UI_Y_W-1:0]        y_clamped;

  // take a request when the result register is free or being drained
  assign pop = q_stat.not_empty && (!out_vld_r || !out_stall);

  // scale toward zero, add offset
  always_comb begin
    y_biased = q_data.y_prod + (q_data.y_prod[PROD_W-1] ? TRUNC_BIAS : '0);
    y_scaled = y_biased >>> GAIN_FRAC_BITS;
    y_sum    = YSUM_W'(y_scaled) + YSUM_W'(y_offset);
  end

  // clamp to the ui rectangle
  always_comb begin
    if (q_data.x_sum < 0) begin
      x_clamped = '0;
    end else if (q_data.x_sum > XSUM_W'(UI_WIDTH - 1)) begin
      x_clamped = X_MAX;
    end else begin
      x_clamped = q_data.x_sum[UI_X_W-1:0];
    end
    if (y_sum < 0) begin
      y_clamped = '0;
    end else if (y_sum > YSUM_W'(UI_HEIGHT - 1)) begin
      y_clamped = Y_MAX;
    end else begin
      y_clamped = y_sum[UI_Y_W-1:0];
    end
  end

  // touch state and counters
  always_comb begin
    held_nxt       = held_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    sample_cnt_nxt = sample_cnt_r;
    press_cnt_nxt  = press_cnt_r;
    fault_cnt_nxt  = fault_cnt_r;
    out_data_nxt   = out_data_r;
    if (pop) begin
      sample_cnt_nxt          = sample_cnt_r + 1'b1;
      out_data_nxt.event_kind = EV_NONE;
      out_data_nxt.ui_x       = '0;
      out_data_nxt.ui_y       = '0;
      case (q_data.cls)
        CLS_FAULT: begin
          fault_cnt_nxt = fault_cnt_r + 1'b1;
        end
        CLS_TOUCH: begin
          press_cnt_nxt           = press_cnt_r + 1'b1;
          held_nxt                = 1'b1;
          held_x_nxt              = x_clamped;
          held_y_nxt              = y_clamped;
          out_data_nxt.event_kind = EV_DOWN;
          out_data_nxt.ui_x       = x_clamped;
          out_data_nxt.ui_y       = y_clamped;
        end
        default: begin
          if (held_r) begin
            held_nxt                = 1'b0;
            out_data_nxt.event_kind = EV_RELEASE;
            out_data_nxt.ui_x       = held_x_r;
            out_data_nxt.ui_y       = held_y_r;
          end
        end
      endcase
      out_data_nxt.sample_total = sample_cnt_nxt;
      out_data_nxt.press_total  = press_cnt_nxt;
      out_data_nxt.fault_total  = fault_cnt_nxt;
    end
  end

  // result register valid
  always_comb begin
    if (pop) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 1'b0;
      held_x_r     <= '0;
      held_y_r     <= '0;
      sample_cnt_r <= '0;
      press_cnt_r  <= '0;
      fault_cnt_r  <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      held_x_r     <= held_x_nxt;
      held_y_r     <= held_y_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      press_cnt_r  <= press_cnt_nxt;
      fault_cnt_r  <= fault_cnt_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/touch_sample_event_mapper.sv
// ----------------------------------------------------------------------------
// A request passes the front register, the queue, then the result register.
// Throughput: one request per cycle unless stalled; the front register, a
// two-entry queue and the result register let intake continue while a
// result is stalled. The front multiply and back clamp are combinational.
// Reset: synchronous active-low rst_n clears the touch state, counters,
// queue and handshake flags and returns the registers to their defaults.
// ----------------------------------------------------------------------------
// touch_sample_event_mapper: touch sample to ui event mapper
// Maps raw touch controller samples to down and release events in the
// ui frame, with sample, press and fault counters and an apb register port.
// ----------------------------------------------------------------------------
module touch_sample_event_mapper #(
  parameter int UI_WIDTH       = tsem_pkg::DEF_UI_WIDTH,
  parameter int UI_HEIGHT      = tsem_pkg::DEF_UI_HEIGHT,
  parameter int GAIN_FRAC_BITS = tsem_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tsem_pkg::in_item_t                 in_data,
  // event results
  output logic                               out_valid,
  input  logic                               out_stall,
  output tsem_pkg::out_item_t                out_data,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsem_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tsem_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tsem_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import tsem_pkg::*;

  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);

  logic signed [XOFF_W-1:0] x_offset_r;
  logic signed [YOFF_W-1:0] y_offset_r;
  logic signed [GAIN_W-1:0] y_gain_r;
  logic                     cfg_wr;
  logic [1:0]               reg_idx;
  logic                     q_push;
  logic                     q_pop;
  work_item_t               q_wr_data;
  work_item_t               q_rd_data;
  q_stat_t                  q_stat;

  // register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r <= '0;
      y_offset_r <= '0;
      y_gain_r   <= GAIN_ONE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_X_OFFSET: x_offset_r <= pwdata[XOFF_W-1:0];
        REG_Y_OFFSET: y_offset_r <= pwdata[YOFF_W-1:0];
        REG_Y_GAIN:   y_gain_r   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_X_OFFSET: prdata = CFG_DATA_W'($unsigned(x_offset_r));
      REG_Y_OFFSET: prdata = CFG_DATA_W'($unsigned(y_offset_r));
      REG_Y_GAIN:   prdata = CFG_DATA_W'($unsigned(y_gain_r));
      default:      prdata = '0;
    endcase
  end

  // intake and classification
  tsem_front #(
    .UI_WIDTH (UI_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .x_offset  (x_offset_r),
    .y_gain    (y_gain_r),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_wr_data)
  );

  // work queue
  tsem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .q_stat    (q_stat)
  );

  // state update and results
  tsem_back #(
    .UI_WIDTH       (UI_WIDTH),
    .UI_HEIGHT      (UI_HEIGHT),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_rd_data),
    .pop       (q_pop),
    .y_offset  (y_offset_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // reset empties the pipeline and frees the intake
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // a full queue behind a stalled result stays full
  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && out_valid && out_stall |=> q_stat.full)
    else $error("queue drained while result stalled");

  // a result with no event carries zero coordinates
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_NONE |-> out_data.ui_x == '0 && out_data.ui_y == '0)
    else $error("coordinates set on a result with no event");

  // the front only pushes into a queue with room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full && !in_stall)
    else $error("push into a full queue");

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the touch sample event mapper
// Drives touch samples through the request channel and, in the later random
// phases, adds random gaps and result channel stalls, and checks every event
// against a local model of the mapping, the touch state and the counters.
// ----------------------------------------------------------------------------
module tb;
  import tsem_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 200;
  // address that maps to no register
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // local copy of the registers
  logic signed [XOFF_W-1:0] x_shift = '0;
  logic signed [YOFF_W-1:0] y_shift = '0;
  logic signed [GAIN_W-1:0] y_scale = 16'sd4096;

  // local copy of the touch state and counters
  logic              touch_held = 1'b0;
  logic [UI_X_W-1:0] held_px = '0;
  logic [UI_Y_W-1:0] held_py = '0;
  logic [CNT_W-1:0]  samples_seen = '0;
  logic [CNT_W-1:0]  presses_seen = '0;
  logic [CNT_W-1:0]  faults_seen = '0;

  out_item_t   pending_events[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_hold = 0;
  logic        idle_on = 1'b0;

  touch_sample_event_mapper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // idle length: mostly none or short, sometimes long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic longint clip(input longint v, input longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // expected event for one accepted sample, updates touch state and counters
  function automatic out_item_t map_sample(input in_item_t s);
    out_item_t r;
    longint    xs;
    longint    ys;
    r = '0;
    r.event_kind = EV_NONE;
    samples_seen = samples_seen + 1;
    if (!s.read_ok) begin
      faults_seen = faults_seen + 1;
    end else if (s.is_pressed && s.point_count != 0) begin
      xs = longint'(DEF_UI_WIDTH - 1) - longint'(s.raw_y) + longint'(x_shift);
      // signed division truncates toward zero
      ys = (longint'(s.raw_x) * longint'(y_scale)) / (longint'(1) << DEF_GAIN_FRAC_BITS)
           + longint'(y_shift);
      presses_seen = presses_seen + 1;
      held_px = UI_X_W'(clip(xs, DEF_UI_WIDTH - 1));
      held_py = UI_Y_W'(clip(ys, DEF_UI_HEIGHT - 1));
      touch_held = 1'b1;
      r.event_kind = EV_DOWN;
      r.ui_x = held_px;
      r.ui_y = held_py;
    end else if (touch_held) begin
      touch_held = 1'b0;
      r.event_kind = EV_RELEASE;
      r.ui_x = held_px;
      r.ui_y = held_py;
    end
    r.sample_total = samples_seen;
    r.press_total = presses_seen;
    r.fault_total = faults_seen;
    return r;
  endfunction

  function automatic in_item_t make_item(input logic ok, input logic pressed,
                                         input int count, input int rx, input int ry);
    in_item_t s;
    s.read_ok = ok;
    s.is_pressed = pressed;
    s.point_count = 4'(count);
    s.raw_x = RAW_W'(rx);
    s.raw_y = RAW_W'(ry);
    return s;
  endfunction

  function automatic in_item_t make_touch(input int rx, input int ry);
    return make_item(1'b1, 1'b1, $urandom_range(1, 15), rx, ry);
  endfunction

  function automatic in_item_t make_noise();
    return make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 15),
                     $urandom_range(0, 2047), $urandom_range(0, 2047));
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input longint unsigned got,
                               input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_seen, name, got, want));
  endtask

  // sends one request, returns at the edge where it is accepted
  task automatic send_sample(input in_item_t s);
    int unsigned gap;
    gap = idle_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // waits until every sent request has its result
  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_X_OFFSET: x_shift = data[XOFF_W-1:0];
      REG_Y_OFFSET: y_shift = data[YOFF_W-1:0];
      REG_Y_GAIN:   y_scale = data[GAIN_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int xo, input int yo, input int g);
    drain();
    cfg_write(REG_X_OFFSET, xo);
    cfg_write(REG_Y_OFFSET, yo);
    cfg_write(REG_Y_GAIN, g);
  endtask

  // touch state transitions under the reset register values
  task automatic test_state_transitions();
    send_sample(make_item(1'b1, 1'b0, 0, 0, 0));
    send_sample(make_item(1'b1, 1'b1, 1, 0, 0));
    // failed read while held keeps the touch
    send_sample(make_item(1'b0, 1'b1, 15, 2047, 2047));
    // pressed with zero points counts as a lift
    send_sample(make_item(1'b1, 1'b1, 0, 2047, 2047));
    send_sample(make_item(1'b1, 1'b0, 15, 2047, 2047));
    send_sample(make_item(1'b1, 1'b1, 15, 2047, 2047));
    send_sample(make_item(1'b1, 1'b0, 0, 0, 0));
  endtask

  // register extremes with corner coordinates
  task automatic test_register_extremes();
    int xo[4] = '{2047, -2048, 0, 1279};
    int yo[4] = '{1023, -1024, 5, -720};
    int gn[4] = '{32767, -32768, -1, 4096};
    for (int i = 0; i < 4; i++) begin
      apply_settings(xo[i], yo[i], gn[i]);
      if (i == 0) cfg_write(REG_UNMAPPED, $urandom);
      send_sample(make_touch(0, 0));
      send_sample(make_touch(2047, 0));
      send_sample(make_touch(2047, 2047));
      send_sample(make_item(1'b1, 1'b0, $urandom_range(0, 15), 0, 2047));
    end
  endtask

  // gestures with random content under random settings, plus noise
  task automatic test_random_traffic();
    int unsigned phase_end;
    int          rx;
    int          ry;
    int          moves;
    int          g;
    for (int p = 0; p < PHASES; p++) begin
      if (p[0]) begin
        g = $urandom_range(0, 65535);
        apply_settings($urandom_range(0, 4095), $urandom_range(0, 2047), g);
      end else begin
        g = $urandom_range(2048, 8192);
        if ($urandom_range(0, 3) == 0) g = -g;
        apply_settings(int'($urandom_range(0, 128)) - 64, int'($urandom_range(0, 128)) - 64, g);
      end
      idle_on = (p != 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          rx = $urandom_range(0, 2047);
          ry = $urandom_range(0, 2047);
          moves = $urandom_range(1, 8);
          for (int m = 0; m < moves; m++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_sample(make_item(1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                    $urandom_range(0, 2047), $urandom_range(0, 2047)));
            end else begin
              send_sample(make_touch(rx, ry));
            end
            rx = int'(clip(rx + int'($urandom_range(0, 64)) - 32, 2047));
            ry = int'(clip(ry + int'($urandom_range(0, 64)) - 32, 2047));
          end
          // lift, either no touch or a touch with no points
          send_sample(make_item(1'b1, $urandom_range(0, 1) ? 1'b1 : 1'b0,
                                0, $urandom_range(0, 2047), $urandom_range(0, 2047)));
        end else begin
          send_sample(make_noise());
        end
      end
    end
    idle_on = 1'b0;
  endtask

  // random result-side stall
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = gap_len();
    end
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_events.push_back(map_sample(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none pending", results_seen));
        end else begin
          want = pending_events.pop_front();
          compare_field("event_kind", out_data.event_kind, want.event_kind);
          compare_field("ui_x", out_data.ui_x, want.ui_x);
          compare_field("ui_y", out_data.ui_y, want.ui_y);
          compare_field("sample_total", out_data.sample_total, want.sample_total);
          compare_field("press_total", out_data.press_total, want.press_total);
          compare_field("fault_total", out_data.fault_total, want.fault_total);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("touch_sample_event_mapper: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_state_transitions();
    test_register_extremes();
    test_random_traffic();
    drain();
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("touch_sample_event_mapper: match");
    end else begin
      $display("touch_sample_event_mapper: mismatch");
    end
    $finish;
  end

endmodule
